// ===== design/hcbp_pkg.sv =====
// shared types and constants for the huffman code bit packer
`timescale 1ns / 1ps

package hcbp_pkg;

  localparam int CMD_W  = 2;
  localparam int SYM_W  = 8;
  localparam int CODE_W = 32;
  localparam int LEN_W  = 6;
  localparam int BYTE_W = 8;
  localparam int PAD_W  = 3;

  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ENCODE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FLUSH  = 2'd2;

  typedef struct packed {
    logic mem_we;
    logic append;
    logic pop;
    logic clear;
    logic show_flush;
  } ctrl_cmd_t;

  typedef struct packed {
    logic append_full;
    logic last_byte;
  } dp_status_t;

endpackage

// ===== design/hcbp_req_if.sv =====
// input transaction channel: command, symbol and code
`timescale 1ns / 1ps

interface hcbp_req_if;
  logic                        valid;
  logic                        ready;
  logic [hcbp_pkg::CMD_W-1:0]  cmd;
  logic [hcbp_pkg::SYM_W-1:0]  symbol;
  logic [hcbp_pkg::CODE_W-1:0] code_value;
  logic [hcbp_pkg::LEN_W-1:0]  code_length;

  modport source (output valid, cmd, symbol, code_value, code_length, input ready);
  modport sink (input valid, cmd, symbol, code_value, code_length, output ready);
endinterface

// ===== design/hcbp_rsp_if.sv =====
// result transaction channel: packed byte and stream flags
`timescale 1ns / 1ps

interface hcbp_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [hcbp_pkg::BYTE_W-1:0] out_byte;
  logic                        has_byte;
  logic [hcbp_pkg::PAD_W-1:0]  pad_bits;
  logic                        is_flush;
  logic                        last;

  modport source (output valid, out_byte, has_byte, pad_bits, is_flush, last, input ready);
  modport sink (input valid, out_byte, has_byte, pad_bits, is_flush, last, output ready);
endinterface

// ===== design/hcbp_ram.sv =====
// generic single port ram with registered read
`timescale 1ns / 1ps

module hcbp_ram #(
  parameter int WIDTH = 38,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== design/hcbp_ctrl.sv =====
// controller state machine for the bit packer
`timescale 1ns / 1ps

module hcbp_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  input  logic [hcbp_pkg::CMD_W-1:0] req_cmd,
  output logic                       req_ready,
  output logic                       rsp_valid,
  input  logic                       rsp_ready,
  input  hcbp_pkg::dp_status_t       status,
  output hcbp_pkg::ctrl_cmd_t        ctrl
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_LOOK  = 2'd1;
  localparam logic [1:0] ST_EMIT  = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       req_fire;
  logic       rsp_fire;

  assign req_ready = (state == ST_IDLE);
  assign rsp_valid = (state == ST_EMIT) || (state == ST_FLUSH);
  assign req_fire  = req_valid && req_ready;
  assign rsp_fire  = rsp_valid && rsp_ready;

  always_comb begin
    state_next      = state;
    ctrl.mem_we     = 1'b0;
    ctrl.append     = 1'b0;
    ctrl.pop        = 1'b0;
    ctrl.clear      = 1'b0;
    ctrl.show_flush = (state == ST_FLUSH);
    unique case (state)
      ST_IDLE: begin
        if (req_fire) begin
          priority if (req_cmd == hcbp_pkg::CMD_LOAD) begin
            ctrl.mem_we = 1'b1;
          end else if (req_cmd == hcbp_pkg::CMD_ENCODE) begin
            state_next = ST_LOOK;
          end else if (req_cmd == hcbp_pkg::CMD_FLUSH) begin
            state_next = ST_FLUSH;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_LOOK: begin
        ctrl.append = 1'b1;
        state_next  = status.append_full ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (rsp_fire) begin
          ctrl.pop = 1'b1;
          if (status.last_byte) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_FLUSH: begin
        if (rsp_fire) begin
          ctrl.clear = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== design/hcbp_dp.sv =====
// datapath: code table, bit buffer and byte extraction
`timescale 1ns / 1ps

module hcbp_dp #(
  parameter int MAX_CODE_LEN = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  hcbp_pkg::ctrl_cmd_t         ctrl,
  output hcbp_pkg::dp_status_t        status,
  input  logic [hcbp_pkg::SYM_W-1:0]  symbol,
  input  logic [hcbp_pkg::CODE_W-1:0] code_value,
  input  logic [hcbp_pkg::LEN_W-1:0]  code_length,
  output logic [hcbp_pkg::BYTE_W-1:0] out_byte,
  output logic                        has_byte,
  output logic [hcbp_pkg::PAD_W-1:0]  pad_bits,
  output logic                        is_flush,
  output logic                        last
);

  localparam int LW    = $clog2(MAX_CODE_LEN + 1);
  localparam int BW    = MAX_CODE_LEN + 7;
  localparam int CW    = $clog2(BW + 1);
  localparam int RW    = MAX_CODE_LEN + LW;
  localparam int DEPTH = 1 << hcbp_pkg::SYM_W;

  logic [LW-1:0]           len_sat;
  logic [RW-1:0]           wdata;
  logic [RW-1:0]           rdata;
  logic [MAX_CODE_LEN-1:0] rd_code;
  logic [LW-1:0]           rd_len;
  logic [BW-1:0]           bits;
  logic [BW-1:0]           bits_next;
  logic [BW-1:0]           mask;
  logic [CW-1:0]           cnt;
  logic [CW-1:0]           cnt_sum;
  logic [CW-1:0]           cnt_next;
  logic [BW-1:0]           byte_shift;
  logic [hcbp_pkg::BYTE_W-1:0] tail_byte;
  logic                    has_tail;

  assign len_sat = (code_length > hcbp_pkg::LEN_W'(MAX_CODE_LEN))
                   ? LW'(MAX_CODE_LEN) : code_length[LW-1:0];
  assign wdata   = {len_sat, code_value[MAX_CODE_LEN-1:0]};

  hcbp_ram #(
    .WIDTH (RW),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ctrl.mem_we),
    .addr  (symbol),
    .wdata (wdata),
    .rdata (rdata)
  );

  assign rd_code = rdata[MAX_CODE_LEN-1:0];
  assign rd_len  = rdata[RW-1 -: LW];
  assign mask    = ~({BW{1'b1}} << rd_len);
  assign cnt_sum = cnt + CW'(rd_len);

  assign status.append_full = (cnt_sum >= CW'(8));
  assign status.last_byte   = ({1'b0, cnt} < (CW + 1)'(16));

  always_comb begin
    bits_next = bits;
    cnt_next  = cnt;
    priority if (ctrl.append) begin
      bits_next = (bits << rd_len) | ({7'b0, rd_code} & mask);
      cnt_next  = cnt_sum;
    end else if (ctrl.pop) begin
      cnt_next = cnt - CW'(8);
    end else if (ctrl.clear) begin
      cnt_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
    bits <= bits_next;
  end

  // leftover bits sit right aligned below cnt
  assign byte_shift = bits >> (cnt - CW'(8));
  assign has_tail   = (cnt[2:0] != 3'd0);
  assign tail_byte  = bits[7:0] << (4'd8 - {1'b0, cnt[2:0]});

  always_comb begin
    if (ctrl.show_flush) begin
      out_byte = has_tail ? tail_byte : '0;
      has_byte = has_tail;
      pad_bits = has_tail ? hcbp_pkg::PAD_W'(4'd8 - {1'b0, cnt[2:0]}) : '0;
      is_flush = 1'b1;
      last     = 1'b1;
    end else begin
      out_byte = byte_shift[7:0];
      has_byte = 1'b1;
      pad_bits = '0;
      is_flush = 1'b0;
      last     = status.last_byte;
    end
  end

endmodule

// ===== design/huffman_code_bit_packer.sv =====
// Huffman code bit packer: a 256-entry code table is loaded with cmd 0 (no
// result), cmd 1 encodes a symbol by appending its code to the bit buffer
// first bit first and emits every completed byte MSB first, and cmd 2 emits
// the partial byte with its padding count and empties the buffer. An encode
// does the registered table read, then the append, then emits up to four
// results; a flush gives a single result. The byte output stage shifts out one
// byte per cycle while the result channel is ready, and a new request is taken
// only after all results of the previous one are delivered.
// An unloaded table entry must not be encoded.
`timescale 1ns / 1ps

module huffman_code_bit_packer #(
  parameter int MAX_CODE_LEN = 32
) (
  input  logic      clk,
  input  logic      rst,
  hcbp_req_if.sink   req,
  hcbp_rsp_if.source rsp
);

  hcbp_pkg::ctrl_cmd_t  ctrl;
  hcbp_pkg::dp_status_t status;

  hcbp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_cmd   (req.cmd),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .status    (status),
    .ctrl      (ctrl)
  );

  hcbp_dp #(
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .status      (status),
    .symbol      (req.symbol),
    .code_value  (req.code_value),
    .code_length (req.code_length),
    .out_byte    (rsp.out_byte),
    .has_byte    (rsp.has_byte),
    .pad_bits    (rsp.pad_bits),
    .is_flush    (rsp.is_flush),
    .last        (rsp.last)
  );

endmodule
